@@ rtl/kpd_pkg.sv @@
// kpd_pkg: shared types, constants and lookup functions for the keypad scanner
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none

package kpd_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    localparam logic [3:0] NO_KEY    = 4'd15;
    localparam logic [3:0] KEY_COUNT = 4'd12;

    localparam logic [1:0] KIND_SCAN = 2'd0;
    localparam logic [1:0] KIND_TEXT = 2'd1;
    localparam logic [1:0] KIND_MENU = 2'd2;

    localparam logic [1:0] STATUS_NONE   = 2'd0;
    localparam logic [1:0] STATUS_NEW    = 2'd1;
    localparam logic [1:0] STATUS_REPEAT = 2'd2;

    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    typedef enum logic [2:0] {
        SCAN_ROW0    = 3'd0,
        SCAN_ROW1    = 3'd1,
        SCAN_ROW2    = 3'd2,
        SCAN_ROW3    = 3'd3,
        SCAN_ARM     = 3'd4,
        SCAN_PRESS   = 3'd5,
        SCAN_HELD    = 3'd6,
        SCAN_RELEASE = 3'd7
    } scan_state_t;

    typedef enum logic [2:0] {
        TAP_IDLE   = 3'd0,
        TAP_PRESS  = 3'd1,
        TAP_HELD   = 3'd2,
        MENU_IDLE  = 3'd3,
        MENU_PRESS = 3'd4,
        MENU_HELD  = 3'd5
    } tap_state_t;

    typedef struct packed {
        logic       key_held;
        logic [3:0] live_key;
        logic [3:0] row_latch;
    } scan_info_t;

    typedef struct packed {
        tap_state_t state;
        logic [3:0] current_key;
        logic [2:0] tap_count;
        logic [1:0] status;
    } tap_info_t;

    // letters in the key's cycle, digit included
    function automatic logic [2:0] kpd_cycle_len(input logic [3:0] key);
        logic [2:0] len;
        case (key)
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd7: len = 3'd4;
            4'd6, 4'd8:                         len = 3'd5;
            default:                            len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kpd_symbol(input logic [3:0] key);
        logic [7:0] ch;
        case (key)
            4'd9:    ch = 8'h2A;
            4'd10:   ch = 8'h30;
            4'd11:   ch = 8'h23;
            default: ch = 8'(8'h31 + {4'd0, key});
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] kpd_first_letter(input logic [3:0] key);
        logic [7:0] ch;
        case (key)
            4'd1:    ch = 8'h41;
            4'd2:    ch = 8'h44;
            4'd3:    ch = 8'h47;
            4'd4:    ch = 8'h4A;
            4'd5:    ch = 8'h4D;
            4'd6:    ch = 8'h50;
            4'd7:    ch = 8'h54;
            default: ch = 8'h57;
        endcase
        return ch;
    endfunction

    // character shown for a key at a tap count, key below twelve
    function automatic logic [7:0] kpd_char(input logic [3:0] key, input logic text_mode,
                                            input logic [2:0] count);
        logic [2:0] len;
        logic [2:0] n;
        logic [7:0] ch;
        len = kpd_cycle_len(key);
        n   = (count > len) ? 3'd1 : count;
        ch  = kpd_symbol(key);
        if (text_mode && len != 3'd0 && count != 3'd0 && n != len)
            ch = 8'(kpd_first_letter(key) + {5'd0, n} - 8'd1);
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ rtl/kpd_scan.sv @@
// kpd_scan: row scanner with press and release debounce
// depends on: kpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module kpd_scan
    import kpd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [1:0]             kind,
    input  wire logic [2:0]             cols,
    input  wire logic                   tick,
    input  wire logic [CFG_W-1:0]       debounce_ticks,
    output scan_info_t                  info
);

    scan_state_t             state_reg, state_next;
    logic [1:0]              row_reg, row_next;
    logic [3:0]              latch_reg, latch_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next, count_tick;
    logic                    held_reg, held_next;
    logic                    low;
    logic                    settled;
    logic [1:0]              col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_ROW0;
            row_reg   <= 2'd0;
            latch_reg <= 4'hF;
            count_reg <= '0;
            held_reg  <= 1'b0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            latch_reg <= latch_next;
            count_reg <= count_next;
            held_reg  <= held_next;
        end
    end

    always_comb
    begin
        count_tick = count_reg;
        if (tick && count_reg != {COUNT_WIDTH{1'b1}})
            count_tick = count_reg + 1'b1;
        low     = (cols != 3'b111);
        settled = (CMP_W'(count_tick) >= CMP_W'(debounce_ticks));

        state_next = state_reg;
        row_next   = row_reg;
        latch_next = latch_reg;
        count_next = count_tick;
        held_next  = held_reg;

        if (kind == KIND_SCAN)
        begin
            unique case (state_reg)
                SCAN_ROW0, SCAN_ROW1, SCAN_ROW2, SCAN_ROW3:
                begin
                    if (!low)
                    begin
                        row_next   = state_reg[1:0];
                        latch_next = ~(4'd1 << state_reg[1:0]);
                        state_next = scan_state_t'({1'b0, state_reg[1:0] + 2'd1});
                    end
                    else
                        state_next = SCAN_ARM;
                end
                SCAN_ARM:
                begin
                    count_next = '0;
                    state_next = SCAN_PRESS;
                end
                SCAN_PRESS:
                begin
                    if (settled)
                    begin
                        if (!low)
                            state_next = SCAN_ROW0;
                        else
                        begin
                            held_next  = 1'b1;
                            state_next = SCAN_HELD;
                        end
                    end
                end
                SCAN_HELD:
                begin
                    if (!low)
                    begin
                        count_next = '0;
                        state_next = SCAN_RELEASE;
                    end
                end
                SCAN_RELEASE:
                begin
                    if (settled)
                    begin
                        if (!low)
                        begin
                            held_next  = 1'b0;
                            state_next = SCAN_ROW0;
                        end
                        else
                            state_next = SCAN_HELD;
                    end
                end
                default:
                    state_next = SCAN_ROW0;
            endcase
        end

        if (!cols[0])
            col = 2'd0;
        else if (!cols[1])
            col = 2'd1;
        else
            col = 2'd2;

        info.key_held  = held_next;
        info.live_key  = {1'b0, row_next, 1'b0} + {2'd0, row_next} + {2'd0, col};
        info.row_latch = latch_next;
    end

endmodule

`default_nettype wire

@@ rtl/kpd_tap.sv @@
// kpd_tap: multi-tap text entry and menu press tracking
// depends on: kpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module kpd_tap
    import kpd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [1:0]             kind,
    input  wire logic                   tick,
    input  wire logic [CFG_W-1:0]       timeout_ticks,
    input  scan_info_t                  scan,
    output tap_info_t                   info
);

    tap_state_t              state_reg, state_next;
    logic [3:0]              cur_reg, cur_next;
    logic [3:0]              prev_reg, prev_next;
    logic [2:0]              taps_reg, taps_next;
    logic [1:0]              status_reg, status_next;
    logic [COUNT_WIDTH-1:0]  idle_reg, idle_next, idle_tick;
    logic [2:0]              len;
    logic [2:0]              n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= TAP_IDLE;
            cur_reg    <= NO_KEY;
            prev_reg   <= NO_KEY;
            taps_reg   <= 3'd0;
            status_reg <= STATUS_NONE;
            idle_reg   <= '0;
        end
        else if (step)
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            prev_reg   <= prev_next;
            taps_reg   <= taps_next;
            status_reg <= status_next;
            idle_reg   <= idle_next;
        end
    end

    always_comb
    begin
        idle_tick = idle_reg;
        if (tick && idle_reg != {COUNT_WIDTH{1'b1}})
            idle_tick = idle_reg + 1'b1;

        len = kpd_cycle_len(cur_reg);
        n   = taps_reg + 3'd1;
        if (len != 3'd0 && n > len)
            n = 3'd1;

        state_next  = state_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        taps_next   = taps_reg;
        status_next = status_reg;
        idle_next   = idle_tick;

        case (kind)
            KIND_SCAN:
            begin
                unique case (state_reg)
                    TAP_IDLE:
                    begin
                        if (scan.key_held)
                        begin
                            state_next  = TAP_PRESS;
                            cur_next    = scan.live_key;
                            status_next = STATUS_REPEAT;
                            if (taps_reg != 3'd0 && (prev_reg != scan.live_key ||
                                CMP_W'(idle_tick) >= CMP_W'(timeout_ticks)))
                            begin
                                status_next = STATUS_NEW;
                                prev_next   = scan.live_key;
                                taps_next   = 3'd0;
                            end
                        end
                        else
                            prev_next = cur_reg;
                    end
                    TAP_PRESS:
                    begin
                        taps_next  = n;
                        state_next = TAP_HELD;
                    end
                    TAP_HELD:
                    begin
                        if (!scan.key_held)
                        begin
                            idle_next  = '0;
                            state_next = TAP_IDLE;
                        end
                    end
                    MENU_IDLE:
                    begin
                        if (scan.key_held)
                            state_next = MENU_PRESS;
                    end
                    MENU_PRESS:
                        state_next = MENU_HELD;
                    MENU_HELD:
                    begin
                        if (!scan.key_held)
                            state_next = MENU_IDLE;
                    end
                    default:
                        state_next = TAP_IDLE;
                endcase
            end
            KIND_TEXT:
            begin
                prev_next   = NO_KEY;
                taps_next   = 3'd0;
                status_next = STATUS_NONE;
                state_next  = TAP_HELD;
                idle_next   = '0;
            end
            KIND_MENU:
                state_next = MENU_PRESS;
            default:
                state_next = state_reg;
        endcase

        info.state       = state_next;
        info.current_key = cur_next;
        info.tap_count   = taps_next;
        info.status      = status_next;
    end

endmodule

`default_nettype wire

@@ rtl/keypad_scan_debounce_multitap.sv @@
// keypad_scan_debounce_multitap: 4x3 keypad scanner with debounce and multi-tap entry
// depends on: kpd_pkg, kpd_scan, kpd_tap
//
// channel   dir   handshake            payload
// s_*       in    s_tvalid / s_tready  tdata {tick_elapsed, column_lines}, tuser kind
// m_*       out   m_tvalid / m_tready  tdata {status, char, index, press, down, rows}
// cfg_*     in    cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// one request per clock unless the output stalls; the result appears in the output register the next cycle
// state updates and the result are computed in the same cycle the request is taken
// s_tready drops only while a result waits and m_tready is low
// rst_n resets all state but the output data register; configuration returns to 25 and 1000 ticks
`timescale 1ns / 1ps
`default_nettype none

module keypad_scan_debounce_multitap
    import kpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [2:0] column_lines, [3] tick_elapsed
    input  wire logic [1:0]        s_tuser,   // [1:0] kind
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,   // [3:0] row_drive, [4] key_down,
                                              // [5] new_press, [9:6] key_index,
                                              // [17:10] key_char, [19:18] entry_status
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] timeout_reg;
    logic             step;
    scan_info_t       scan;
    tap_info_t        tap;
    logic [3:0]       shown;
    logic [7:0]       ch;
    logic             text_mode;
    logic             press;
    logic             valid_reg;
    logic [19:0]      data_reg, data_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = !valid_reg || m_tready;
    assign step      = s_tvalid && s_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {4'd0, data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= CFG_W'(25);
            timeout_reg  <= CFG_W'(1000);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_data;
                CFG_TIMEOUT:  timeout_reg  <= cfg_data;
            endcase
        end
    end

    kpd_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .kind           (s_tuser),
        .cols           (s_tdata[2:0]),
        .tick           (s_tdata[3]),
        .debounce_ticks (debounce_reg),
        .info           (scan)
    );

    kpd_tap u_tap (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .kind           (s_tuser),
        .tick           (s_tdata[3]),
        .timeout_ticks  (timeout_reg),
        .scan           (scan),
        .info           (tap)
    );

    always_comb
    begin
        text_mode = (tap.state == TAP_IDLE || tap.state == TAP_PRESS ||
                     tap.state == TAP_HELD);
        press     = scan.key_held && (tap.state == TAP_PRESS || tap.state == MENU_PRESS);
        shown     = scan.key_held ? scan.live_key : tap.current_key;
        ch        = 8'd0;
        if (shown < KEY_COUNT)
            ch = kpd_char(shown, text_mode, tap.tap_count);
        else
            shown = 4'd0;
        data_next = {tap.status, ch, shown, press, scan.key_held, scan.row_latch};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_tready)
            valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

@@ tb/sv/keypad_scan_debounce_multitap_tb.sv @@
// keypad_scan_debounce_multitap_tb: self-checking bench for the keypad scanner and multi-tap entry
// depends on: kpd_pkg, keypad_scan_debounce_multitap
// directed steps first, then reactive key strokes over several timing settings, checked per field
`timescale 1ns / 1ps

module keypad_scan_debounce_multitap_tb;
    import kpd_pkg::*;

    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0] KIND_NONE   = 2'd3;
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] ch;
        logic [3:0] key;
        logic       press;
        logic       down;
        logic [3:0] rows;
    } result_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] cols;
        logic       tick;
        bit         typed;
        result_t    want;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [23:0]      m_tdata;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // predicted block state
    scan_state_t            scan_st;
    logic [1:0]             drive_row;
    logic [3:0]             row_out;
    logic [COUNT_WIDTH-1:0] bounce_cnt;
    logic                   held;
    tap_state_t             tap_st;
    logic [3:0]             cur_key;
    logic [3:0]             last_key;
    logic [2:0]             taps;
    logic [1:0]             entry_st;
    logic [COUNT_WIDTH-1:0] idle_cnt;
    logic [CFG_W-1:0]       bounce_ticks;
    logic [CFG_W-1:0]       tap_window;

    result_t  expected_q[$];
    dir_row_t dir_q[$];
    result_t  want_res;
    result_t  got_res;
    int       errors;
    int       steps_sent;
    int       cycle_count;
    bit       idle_on;

    keypad_scan_debounce_multitap i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [3:0] key_at(input logic [1:0] row, input logic [2:0] cols);
        logic [3:0] col;
        if (!cols[0])
            col = 4'd0;
        else if (!cols[1])
            col = 4'd1;
        else
            col = 4'd2;
        return {2'b00, row} * 4'd3 + col;
    endfunction

    function automatic logic [2:0] letters_on(input logic [3:0] key);
        case (key)
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd7: return 3'd4;
            4'd6, 4'd8:                         return 3'd5;
            default:                            return 3'd0;
        endcase
    endfunction

    // n of zero gives the printed symbol, else the n-th entry of the key's cycle
    function automatic logic [7:0] key_glyph(input logic [3:0] key, input logic [2:0] n);
        string cyc;
        case (key)
            4'd1:    cyc = "ABC2";
            4'd2:    cyc = "DEF3";
            4'd3:    cyc = "GHI4";
            4'd4:    cyc = "JKL5";
            4'd5:    cyc = "MNO6";
            4'd6:    cyc = "PQRS7";
            4'd7:    cyc = "TUV8";
            4'd8:    cyc = "WXYZ9";
            default: cyc = "";
        endcase
        if (n != 3'd0 && cyc.len() != 0)
            return cyc[n - 1];
        case (key)
            4'd9:    return "*";
            4'd10:   return "0";
            4'd11:   return "#";
            default: return 8'h31 + {4'd0, key};
        endcase
    endfunction

    function automatic result_t res_of(input logic [3:0] rows, input logic down,
                                       input logic press, input logic [3:0] key,
                                       input logic [7:0] ch, input logic [1:0] status);
        result_t r;
        r.rows   = rows;
        r.down   = down;
        r.press  = press;
        r.key    = key;
        r.ch     = ch;
        r.status = status;
        return r;
    endfunction

    task automatic keypad_step(input logic [1:0] kind, input logic [2:0] cols,
                               input logic tick, output result_t res);
        logic       pressed;
        logic [2:0] n;
        logic [2:0] len;
        logic [3:0] shown;
        pressed = (cols != 3'b111);
        if (tick)
        begin
            if (bounce_cnt != COUNT_TOP)
                bounce_cnt = bounce_cnt + 1'b1;
            if (idle_cnt != COUNT_TOP)
                idle_cnt = idle_cnt + 1'b1;
        end
        if (kind == KIND_SCAN)
        begin
            case (scan_st)
                SCAN_ROW0, SCAN_ROW1, SCAN_ROW2, SCAN_ROW3:
                    if (!pressed)
                    begin
                        drive_row = 2'(scan_st);
                        row_out   = ~(4'b0001 << drive_row);
                        scan_st   = scan_state_t'({1'b0, drive_row + 2'd1});
                    end
                    else
                        scan_st = SCAN_ARM;
                SCAN_ARM:
                begin
                    bounce_cnt = '0;
                    scan_st    = SCAN_PRESS;
                end
                SCAN_PRESS:
                    if (bounce_cnt >= bounce_ticks)
                    begin
                        if (!pressed)
                            scan_st = SCAN_ROW0;
                        else
                        begin
                            held    = 1'b1;
                            scan_st = SCAN_HELD;
                        end
                    end
                SCAN_HELD:
                    if (!pressed)
                    begin
                        bounce_cnt = '0;
                        scan_st    = SCAN_RELEASE;
                    end
                default:
                    if (bounce_cnt >= bounce_ticks)
                    begin
                        if (!pressed)
                        begin
                            held    = 1'b0;
                            scan_st = SCAN_ROW0;
                        end
                        else
                            scan_st = SCAN_HELD;
                    end
            endcase
            case (tap_st)
                TAP_IDLE:
                    if (held)
                    begin
                        tap_st   = TAP_PRESS;
                        cur_key  = key_at(drive_row, cols);
                        entry_st = STATUS_REPEAT;
                        if (taps != 3'd0 && (last_key != cur_key || idle_cnt >= tap_window))
                        begin
                            entry_st = STATUS_NEW;
                            last_key = cur_key;
                            taps     = 3'd0;
                        end
                    end
                    else
                        last_key = cur_key;
                TAP_PRESS:
                begin
                    n   = taps + 3'd1;
                    len = letters_on(cur_key);
                    if (len != 3'd0 && n > len)
                        n = 3'd1;
                    taps   = n;
                    tap_st = TAP_HELD;
                end
                TAP_HELD:
                    if (!held)
                    begin
                        idle_cnt = '0;
                        tap_st   = TAP_IDLE;
                    end
                MENU_IDLE:
                    if (held)
                        tap_st = MENU_PRESS;
                MENU_PRESS:
                    tap_st = MENU_HELD;
                MENU_HELD:
                    if (!held)
                        tap_st = MENU_IDLE;
                default:
                    tap_st = TAP_IDLE;
            endcase
        end
        else if (kind == KIND_TEXT)
        begin
            last_key = NO_KEY;
            taps     = 3'd0;
            entry_st = STATUS_NONE;
            tap_st   = TAP_HELD;
            idle_cnt = '0;
        end
        else if (kind == KIND_MENU)
            tap_st = MENU_PRESS;

        shown = held ? key_at(drive_row, cols) : cur_key;
        res   = res_of(row_out, held, held && (tap_st == TAP_PRESS || tap_st == MENU_PRESS),
                       4'd0, 8'd0, entry_st);
        if (shown < KEY_COUNT)
        begin
            len     = letters_on(shown);
            n       = (taps > len) ? 3'd1 : taps;
            res.key = shown;
            res.ch  = key_glyph(shown, (tap_st <= TAP_HELD && len != 3'd0) ? n : 3'd0);
        end
    endtask

    task automatic send_step(input logic [1:0] kind, input logic [2:0] cols, input logic tick,
                             input bit typed, input result_t want);
        result_t model;
        int      gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, tick, cols};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        keypad_step(kind, cols, tick, model);
        expected_q.push_back(typed ? want : model);
        if (kind != KIND_NONE)
            steps_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] to);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= db;
        do @(posedge clk); while (!cfg_ready);
        bounce_ticks = db;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= to;
        do @(posedge clk); while (!cfg_ready);
        tap_window = to;
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic [1:0] kind, input logic [2:0] cols, input logic tick,
                           input bit typed, input result_t want);
        dir_row_t r;
        r.kind  = kind;
        r.cols  = cols;
        r.tick  = tick;
        r.typed = typed;
        r.want  = want;
        dir_q.push_back(r);
    endtask

    initial
    begin : sink_ready
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result with no request pending: %h", m_tdata);
            end
            else
            begin
                want_res = expected_q.pop_front();
                got_res  = result_t'(m_tdata[19:0]);
                if (got_res.rows !== want_res.rows || got_res.down !== want_res.down ||
                    got_res.press !== want_res.press || got_res.key !== want_res.key ||
                    got_res.ch !== want_res.ch || got_res.status !== want_res.status)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch exp rows=%h down=%b press=%b key=%0d char=%h st=%0d",
                                 want_res.rows, want_res.down, want_res.press, want_res.key,
                                 want_res.ch, want_res.status);
                        $display("         got rows=%h down=%b press=%b key=%0d char=%h st=%0d",
                                 got_res.rows, got_res.down, got_res.press, got_res.key,
                                 got_res.ch, got_res.status);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int               phase;
        int               target;
        int               n;
        int               gap;
        int               pick;
        bit               bounce;
        logic [1:0]       key_row;
        logic [2:0]       key_cols;
        logic [CFG_W-1:0] db;
        logic [CFG_W-1:0] to;
        dir_row_t         r;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        s_tuser     = KIND_SCAN;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_DEBOUNCE;
        cfg_data    = '0;
        idle_on     = 1'b0;
        errors      = 0;
        steps_sent  = 0;
        cycle_count = 0;
        key_row     = 2'd0;
        key_cols    = 3'b110;

        scan_st      = SCAN_ROW0;
        drive_row    = 2'd0;
        row_out      = 4'hF;
        bounce_cnt   = '0;
        held         = 1'b0;
        tap_st       = TAP_IDLE;
        cur_key      = NO_KEY;
        last_key     = NO_KEY;
        taps         = 3'd0;
        entry_st     = STATUS_NONE;
        idle_cnt     = '0;
        bounce_ticks = 16'd25;
        tap_window   = 16'd1000;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // shortest debounce, longest multi-tap window
        set_timing(16'd1, 16'hFFFF);
        idle_on = 1'b1;

        add_row(KIND_SCAN, 3'b111, 1'b0, 1'b1,
                res_of(4'hE, 1'b0, 1'b0, 4'd0, 8'd0, STATUS_NONE));
        add_row(KIND_NONE, 3'b000, 1'b1, 1'b1,
                res_of(4'hE, 1'b0, 1'b0, 4'd0, 8'd0, STATUS_NONE));
        add_row(KIND_SCAN, 3'b110, 1'b1, 1'b1,
                res_of(4'hE, 1'b0, 1'b0, 4'd0, 8'd0, STATUS_NONE));
        add_row(KIND_SCAN, 3'b110, 1'b1, 1'b1,
                res_of(4'hE, 1'b0, 1'b0, 4'd0, 8'd0, STATUS_NONE));
        // first press after reset reports a repeat tap
        add_row(KIND_SCAN, 3'b110, 1'b1, 1'b1,
                res_of(4'hE, 1'b1, 1'b1, 4'd0, "1", STATUS_REPEAT));
        add_row(KIND_SCAN, 3'b110, 1'b0, 1'b0, '0);
        add_row(KIND_SCAN, 3'b111, 1'b1, 1'b0, '0);
        add_row(KIND_SCAN, 3'b111, 1'b1, 1'b0, '0);
        add_row(KIND_MENU, 3'b101, 1'b0, 1'b0, '0);
        add_row(KIND_SCAN, 3'b111, 1'b1, 1'b0, '0);
        add_row(KIND_SCAN, 3'b101, 1'b1, 1'b0, '0);
        add_row(KIND_SCAN, 3'b101, 1'b1, 1'b0, '0);
        add_row(KIND_SCAN, 3'b101, 1'b1, 1'b0, '0);
        add_row(KIND_SCAN, 3'b101, 1'b0, 1'b0, '0);
        add_row(KIND_TEXT, 3'b000, 1'b1, 1'b0, '0);
        add_row(KIND_SCAN, 3'b111, 1'b1, 1'b0, '0);
        add_row(KIND_SCAN, 3'b111, 1'b1, 1'b0, '0);
        add_row(KIND_SCAN, 3'b011, 1'b1, 1'b0, '0);
        add_row(KIND_SCAN, 3'b011, 1'b1, 1'b0, '0);
        add_row(KIND_SCAN, 3'b011, 1'b1, 1'b1,
                res_of(4'hE, 1'b1, 1'b1, 4'd2, "3", STATUS_REPEAT));
        add_row(KIND_SCAN, 3'b011, 1'b0, 1'b0, '0);
        add_row(KIND_NONE, 3'b111, 1'b1, 1'b0, '0);
        add_row(KIND_SCAN, 3'b100, 1'b0, 1'b0, '0);

        while (dir_q.size() != 0)
        begin
            r = dir_q.pop_front();
            send_step(r.kind, r.cols, r.tick, r.typed, r.want);
        end
        while (held)
            send_step(KIND_SCAN, 3'b111, 1'b1, 1'b0, '0);

        // long debounce while a key is held
        drain();
        idle_on = 1'b0;
        set_timing(16'd100, 16'hFFFF);
        while (!held)
            send_step(KIND_SCAN, 3'b101, 1'b1, 1'b0, '0);
        repeat (40) send_step(KIND_SCAN, 3'b101, 1'b1, 1'b0, '0);

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    db = 16'd1;
                    to = 16'd1;
                end
                1:
                begin
                    db = 16'd2;
                    to = 16'hFFFF;
                end
                default:
                begin
                    db = CFG_W'($urandom_range(1, 6));
                    to = CFG_W'($urandom_range(1, 60));
                end
            endcase
            drain();
            idle_on = (phase != 7);
            set_timing(db, to);
            target = steps_sent + 200;
            while (steps_sent < target)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 15)
                begin
                    // same key again half the time, so repeat taps and wraps occur
                    if ($urandom_range(0, 1) == 0)
                    begin
                        key_row  = 2'($urandom_range(0, 3));
                        key_cols = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 6))
                                                               : ~(3'b001 << $urandom_range(0, 2));
                    end
                    n = 0;
                    while (!(scan_st <= SCAN_ROW3 && drive_row == key_row) && n < 200)
                    begin
                        send_step(KIND_SCAN, 3'b111, 1'($urandom_range(0, 1)), 1'b0, '0);
                        n++;
                    end
                    bounce = ($urandom_range(0, 7) == 0);
                    n = 0;
                    while (!held && n < 200)
                    begin
                        send_step(KIND_SCAN, (bounce && n == 2) ? 3'b111 : key_cols,
                                  $urandom_range(0, 3) != 0, 1'b0, '0);
                        n++;
                    end
                    repeat ($urandom_range(0, 4))
                        send_step(KIND_SCAN, ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 6))
                                                                         : key_cols,
                                  $urandom_range(0, 3) != 0, 1'b0, '0);
                    n = 0;
                    while (held && n < 200)
                    begin
                        send_step(KIND_SCAN, ($urandom_range(0, 7) == 0) ? key_cols : 3'b111,
                                  $urandom_range(0, 3) != 0, 1'b0, '0);
                        n++;
                    end
                    gap = $urandom_range(0, 2);
                    if ($urandom_range(0, 3) == 0)
                        gap = $urandom_range(0, (2 * int'(tap_window) + 2 > 80) ? 80
                                                                               : 2 * tap_window + 2);
                    repeat (gap)
                        send_step(KIND_SCAN, 3'b111, $urandom_range(0, 3) != 0, 1'b0, '0);
                end
                else if (pick < 17)
                    send_step(KIND_TEXT, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              1'b0, '0);
                else if (pick == 17)
                    send_step(KIND_MENU, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              1'b0, '0);
                else
                    send_step(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
